>>> rtl/rds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rds_pkg;

    // Table depth default and register file geometry
    localparam int IN_FLIGHT_DEF = 16;
    localparam int REG_TYPES     = 4;
    localparam int REGS_PER_TYPE = 64;

    // Field widths
    localparam int REQ_W   = 3;
    localparam int TAG_W   = 4;
    localparam int RTYPE_W = 2;
    localparam int RIDX_W  = 6;
    localparam int OCNT_W  = 6;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MARK_EXEC   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MARK_FLUSH  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CHECK_READ  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CHECK_WRITE = 3'd5;
    localparam logic [REQ_W-1:0] REQ_PURGE       = 3'd6;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [TAG_W-1:0]   instr_tag;
        logic [RTYPE_W-1:0] reg_type;
        logic [RIDX_W-1:0]  reg_index;
        logic               first_reg_valid;
        logic               second_reg_valid;
        logic [RTYPE_W-1:0] second_reg_type;
        logic [RIDX_W-1:0]  second_reg_index;
        logic               is_mul_or_div;
        logic               is_load;
        logic               is_store_data;
    } t_req;

    typedef struct packed {
        logic              can_proceed;
        logic              from_forward;
        logic [TAG_W-1:0]  forward_tag;
        logic [OCNT_W-1:0] outstanding_count;
    } t_rsp;

endpackage

`default_nettype wire

>>> rtl/rds_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rds_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/register_dependency_scoreboard.sv
// A word accepted into the input register is looked up and applied as it moves into
//   the result register; it waits in the input register while a result is stalled.
// Throughput: one word per cycle while results are taken; the whole table search and
//   update sits in the single stage between the input register and the result register.
// Reset (synchronous, active low) empties the table: no destinations, zero ages,
//   clear flags, zero count, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module register_dependency_scoreboard #(
    parameter int IN_FLIGHT = rds_pkg::IN_FLIGHT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rds_stream_if.sink    i_req,
    rds_stream_if.source  o_rsp
);

    // Count holds up to two destinations per entry
    localparam int CNT_W = $clog2(2 * IN_FLIGHT + 1);

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    logic           r_in_valid;
    rds_pkg::t_req  r_in;
    logic           r_out_valid;
    rds_pkg::t_rsp  r_out;
    logic           w_advance;

    // ------------------------------------------------------------------
    // Table state: per tag two destination slots, an age row and flags
    // ------------------------------------------------------------------
    logic [IN_FLIGHT-1:0][1:0]                       r_dv,  n_dv;
    logic [IN_FLIGHT-1:0][1:0][rds_pkg::RTYPE_W-1:0] r_dty, n_dty;
    logic [IN_FLIGHT-1:0][1:0][rds_pkg::RIDX_W-1:0]  r_dix, n_dix;
    logic [IN_FLIGHT-1:0][IN_FLIGHT-1:0]             r_age, n_age;
    logic [IN_FLIGHT-1:0]                            r_exec,   n_exec;
    logic [IN_FLIGHT-1:0]                            r_flush,  n_flush;
    logic [IN_FLIGHT-1:0]                            r_muldiv, n_muldiv;
    logic [IN_FLIGHT-1:0]                            r_load,   n_load;
    logic [CNT_W-1:0]                                r_count,  n_count;

    rds_pkg::t_rsp  n_rsp;

    // Lookup results
    logic [IN_FLIGHT-1:0]     w_sel;
    logic [IN_FLIGHT-1:0]     w_hit_rd, w_hit_w1, w_hit_w2;
    logic [IN_FLIGHT-1:0]     w_yng_rd, w_yng_w1, w_yng_w2;
    logic [IN_FLIGHT-1:0]     w_drop;
    logic [2*IN_FLIGHT-1:0]   w_drop_slots;
    logic [2*IN_FLIGHT-1:0]   w_valid_flat;
    logic [IN_FLIGHT-1:0]     w_age_diag;
    logic                     w_rec1, w_rec2;
    logic [1:0]               w_added;
    logic [rds_pkg::TAG_W-1:0] w_fwd_tag;
    logic                     w_p_exec, w_p_muldiv, w_p_load;
    logic                     w_blk1, w_blk2;

    // Move a word from the input register to the result register when the
    // result register is empty or being drained this cycle.
    assign w_advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready   = !r_in_valid || w_advance;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.data    = r_out;

    // Youngest among hitting entries: no other hitting entry was inserted later.
    // Bit j of row t set means j is older than t.
    function automatic logic [IN_FLIGHT-1:0] f_youngest(
        input logic [IN_FLIGHT-1:0]                hit,
        input logic [IN_FLIGHT-1:0][IN_FLIGHT-1:0] age
    );
        logic [IN_FLIGHT-1:0] yng;
        yng = hit;
        for (int t = 0; t < IN_FLIGHT; t++) begin
            for (int j = 0; j < IN_FLIGHT; j++) begin
                if (hit[j] && age[j][t]) begin
                    yng[t] = 1'b0;
                end
            end
        end
        return yng;
    endfunction

    // ------------------------------------------------------------------
    // Parallel search over all entries
    // ------------------------------------------------------------------
    always_comb begin
        for (int t = 0; t < IN_FLIGHT; t++) begin
            // Tags at or beyond the table depth select nothing
            w_sel[t]    = (int'(r_in.instr_tag) == t);
            w_hit_rd[t] = 1'b0;
            w_hit_w1[t] = 1'b0;
            w_hit_w2[t] = 1'b0;
            for (int k = 0; k < 2; k++) begin
                if (r_dv[t][k] && r_dty[t][k] == r_in.reg_type
                        && r_dix[t][k] == r_in.reg_index) begin
                    w_hit_rd[t] = 1'b1;
                end
                if (r_dv[t][k] && r_dty[t][k] == r_in.second_reg_type
                        && r_dix[t][k] == r_in.second_reg_index) begin
                    w_hit_w2[t] = 1'b1;
                end
            end
            // First write destination uses the same register as a read check
            w_hit_w1[t] = w_hit_rd[t];
        end
        w_yng_rd = f_youngest(w_hit_rd, r_age);
        w_yng_w1 = f_youngest(w_hit_w1, r_age);
        w_yng_w2 = f_youngest(w_hit_w2, r_age);

        // Pick the read producer's flags and tag (at most one bit is set)
        w_fwd_tag  = '0;
        w_p_exec   = 1'b0;
        w_p_muldiv = 1'b0;
        w_p_load   = 1'b0;
        w_blk1     = 1'b0;
        w_blk2     = 1'b0;
        for (int t = 0; t < IN_FLIGHT; t++) begin
            if (w_yng_rd[t]) begin
                w_fwd_tag  = w_fwd_tag | rds_pkg::TAG_W'(t);
                w_p_exec   = w_p_exec   | r_exec[t];
                w_p_muldiv = w_p_muldiv | r_muldiv[t];
                w_p_load   = w_p_load   | r_load[t];
            end
            // A write waits on a youngest producer that has not executed
            w_blk1 = w_blk1 | (w_yng_w1[t] & ~r_exec[t]);
            w_blk2 = w_blk2 | (w_yng_w2[t] & ~r_exec[t]);
        end
    end

    // ------------------------------------------------------------------
    // Table update
    // ------------------------------------------------------------------
    always_comb begin
        // Skip the zero register and anything outside the register files
        w_rec1 = r_in.first_reg_valid
            && !(r_in.reg_type == '0 && r_in.reg_index == '0)
            && int'(r_in.reg_type) < rds_pkg::REG_TYPES
            && int'(r_in.reg_index) < rds_pkg::REGS_PER_TYPE;
        w_rec2 = r_in.second_reg_valid
            && !(r_in.second_reg_type == '0 && r_in.second_reg_index == '0)
            && int'(r_in.second_reg_type) < rds_pkg::REG_TYPES
            && int'(r_in.second_reg_index) < rds_pkg::REGS_PER_TYPE;

        n_dv     = r_dv;
        n_dty    = r_dty;
        n_dix    = r_dix;
        n_age    = r_age;
        n_exec   = r_exec;
        n_flush  = r_flush;
        n_muldiv = r_muldiv;
        n_load   = r_load;
        w_drop   = '0;
        w_added  = 2'd0;

        case (r_in.req_type)
            rds_pkg::REQ_INSERT: begin
                w_drop  = w_sel;
                w_added = (|w_sel) ? ({1'b0, w_rec1} + {1'b0, w_rec2}) : 2'd0;
            end
            rds_pkg::REQ_REMOVE: begin
                w_drop = w_sel;
            end
            rds_pkg::REQ_PURGE: begin
                w_drop = r_flush;
            end
            default: begin
                w_drop = '0;
            end
        endcase

        for (int t = 0; t < IN_FLIGHT; t++) begin
            w_drop_slots[2*t]   = w_drop[t] & r_dv[t][0];
            w_drop_slots[2*t+1] = w_drop[t] & r_dv[t][1];
            if (w_drop[t]) begin
                n_dv[t]     = 2'b00;
                n_exec[t]   = 1'b0;
                n_flush[t]  = 1'b0;
                n_muldiv[t] = 1'b0;
                n_load[t]   = 1'b0;
            end
        end

        case (r_in.req_type)
            rds_pkg::REQ_INSERT: begin
                for (int t = 0; t < IN_FLIGHT; t++) begin
                    if (w_sel[t]) begin
                        n_dv[t][0]  = w_rec1;
                        n_dty[t][0] = r_in.reg_type;
                        n_dix[t][0] = r_in.reg_index;
                        n_dv[t][1]  = w_rec2;
                        n_dty[t][1] = r_in.second_reg_type;
                        n_dix[t][1] = r_in.second_reg_index;
                        n_muldiv[t] = r_in.is_mul_or_div;
                        n_load[t]   = r_in.is_load;
                    end
                    // New entry is younger than every other; drop its old column
                    for (int j = 0; j < IN_FLIGHT; j++) begin
                        n_age[t][j] = w_sel[t] ? (j != t) : (r_age[t][j] & ~w_sel[j]);
                    end
                end
            end
            rds_pkg::REQ_MARK_EXEC: begin
                n_exec = r_exec | w_sel;
            end
            rds_pkg::REQ_MARK_FLUSH: begin
                n_flush = r_flush | w_sel;
            end
            default: begin
                n_age = r_age;
            end
        endcase

        n_count = r_count - CNT_W'($countones(w_drop_slots)) + CNT_W'(w_added);
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    always_comb begin
        n_rsp                   = '0;
        n_rsp.can_proceed       = 1'b1;
        n_rsp.outstanding_count = rds_pkg::OCNT_W'(n_count);
        case (r_in.req_type)
            rds_pkg::REQ_CHECK_READ: begin
                if (|w_yng_rd) begin
                    // Forward only an executed, non mul/div result; loads feed
                    // store data only
                    if (w_p_exec && !w_p_muldiv && !(w_p_load && !r_in.is_store_data)) begin
                        n_rsp.from_forward = 1'b1;
                        n_rsp.forward_tag  = w_fwd_tag;
                    end else begin
                        n_rsp.can_proceed = 1'b0;
                    end
                end
            end
            rds_pkg::REQ_CHECK_WRITE: begin
                n_rsp.can_proceed = !((r_in.first_reg_valid && w_blk1)
                    || (r_in.second_reg_valid && w_blk2)) || r_in.is_load;
            end
            default: begin
                n_rsp.can_proceed = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dv        <= '0;
            r_age       <= '0;
            r_exec      <= '0;
            r_flush     <= '0;
            r_muldiv    <= '0;
            r_load      <= '0;
            r_count     <= '0;
        end else begin
            // Hold the input word until it can advance
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            // Apply the table update with the word that produced it
            if (w_advance) begin
                r_dv     <= n_dv;
                r_age    <= n_age;
                r_exec   <= n_exec;
                r_flush  <= n_flush;
                r_muldiv <= n_muldiv;
                r_load   <= n_load;
                r_count  <= n_count;
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (w_advance) begin
            r_out <= n_rsp;
            r_dty <= n_dty;
            r_dix <= n_dix;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    always_comb begin
        for (int t = 0; t < IN_FLIGHT; t++) begin
            w_valid_flat[2*t]   = r_dv[t][0];
            w_valid_flat[2*t+1] = r_dv[t][1];
            w_age_diag[t]       = r_age[t][t];
        end
    end

    // Running count tracks the live destination slots
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(w_valid_flat)))
        else $error("dependency count out of step with valid slots");

    // No entry is ever older than itself
    a_age_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_age_diag == '0)
        else $error("age matrix diagonal set");

    // Age order gives a single youngest producer
    a_one_producer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> ($onehot0(w_yng_rd) && $onehot0(w_yng_w2)))
        else $error("more than one youngest producer");

    // A forwarded read always proceeds
    a_fwd_proceeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.from_forward) |-> r_out.can_proceed)
        else $error("forward offered on a stalled read");

    // A stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
